// ===== hdl/dqv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dotted-quad validator package
// Shared constants, character codes and the word type of the input stage.
// ----------------------------------------------------------------------------
package dqv_pkg;

  localparam int unsigned MAX_CHARS_DEF = 15;
  localparam int unsigned MIN_CHARS     = 7;
  localparam int unsigned NUM_FIELDS    = 4;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ACCUM_W = 9;
  localparam int unsigned FCNT_W  = 3;
  localparam int unsigned QUAD_W  = 32;

  localparam logic [ACCUM_W-1:0] FIELD_MAX = 9'd255;
  localparam logic [ACCUM_W-1:0] ACCUM_SAT = 9'd256;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } dqv_char_t;

endpackage : dqv_pkg
`default_nettype wire

// ===== hdl/dqv_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dotted-quad validator channels
// Character, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dqv_char_if;
  logic                           valid;
  logic                           ready;
  logic [dqv_pkg::CHAR_W-1:0]     char_code;
  logic                           last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface : dqv_char_if

interface dqv_res_if;
  logic                           valid;
  logic                           ready;
  logic                           is_valid;
  logic [dqv_pkg::QUAD_W-1:0]     quad_value;

  modport source (output valid, output is_valid, output quad_value, input ready);
  modport sink   (input valid, input is_valid, input quad_value, output ready);
endinterface : dqv_res_if

interface dqv_cfg_if;
  logic valid;
  logic ready;
  logic mask_mode;

  modport source (output valid, output mask_mode, input ready);
  modport sink   (input valid, input mask_mode, output ready);
endinterface : dqv_cfg_if
`default_nettype wire

// ===== hdl/dqv_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dotted-quad validator input register
// Capture one character word per cycle while the scanner takes them; hold it until the scanner takes it.
// ----------------------------------------------------------------------------
module dqv_in_reg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  dqv_char_if.sink          in_i,
  input  wire logic         take_i,
  output dqv_pkg::dqv_char_t word_o,
  output logic              valid_o
);

  logic               valid_q, valid_d;
  dqv_pkg::dqv_char_t word_q;
  logic               accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.char_code <= in_i.char_code;
      word_q.last_char <= in_i.last_char;
    end
  end

  assign word_o  = word_q;
  assign valid_o = valid_q;

endmodule : dqv_in_reg
`default_nettype wire

// ===== hdl/dqv_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dotted-quad validator scanner
// Per-character token, length and range update with the registered result.
// ----------------------------------------------------------------------------
module dqv_scan #(
  parameter int unsigned MAX_CHARS = dqv_pkg::MAX_CHARS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dqv_pkg::dqv_char_t word_i,
  input  wire logic               valid_i,
  input  wire logic               mask_mode_i,
  output logic                    take_o,
  dqv_res_if.source               out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);
  localparam int unsigned ACC_W = dqv_pkg::ACCUM_W;
  localparam int unsigned FC_W  = dqv_pkg::FCNT_W;
  localparam int unsigned Q_W   = dqv_pkg::QUAD_W;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             inf_q, inf_d;
  logic [FC_W-1:0]  fc_q, fc_d;
  logic             bad_q, bad_d;
  logic             rng_q, rng_d;
  logic [Q_W-1:0]   pack_q, pack_d;

  logic             out_valid_q, out_valid_d;
  logic             out_ok_q;
  logic [Q_W-1:0]   out_quad_q;

  logic             out_free;
  logic             res_ok;
  logic [Q_W-1:0]   res_quad;

  assign out_free = !out_valid_q || out_o.ready;
  assign take_o   = valid_i && (!word_i.last_char || out_free);

  always_comb begin
    logic [CNT_W-1:0] cnt_n;
    logic [ACC_W-1:0] acc_n;
    logic             inf_n;
    logic [FC_W-1:0]  fc_n;
    logic             bad_n;
    logic             rng_n;
    logic [Q_W-1:0]   pack_n;
    logic [3:0]       dig;
    logic [12:0]      prod;
    logic [4:0]       sh;
    logic [Q_W-1:0]   inv;
    logic             ok;

    cnt_n  = cnt_q;
    acc_n  = acc_q;
    inf_n  = inf_q;
    fc_n   = fc_q;
    bad_n  = bad_q;
    rng_n  = rng_q;
    pack_n = pack_q;
    dig    = 4'(word_i.char_code - dqv_pkg::CHAR_ZERO);
    prod   = 13'({acc_q, 3'b000}) + 13'({acc_q, 1'b0}) + 13'(dig);

    if (cnt_q >= CNT_W'(MAX_CHARS)) begin
      rng_n = 1'b1;
    end else begin
      cnt_n = cnt_q + CNT_W'(1);
    end

    if (word_i.char_code inside {[dqv_pkg::CHAR_ZERO:dqv_pkg::CHAR_NINE]}) begin
      if (!inf_q) begin
        inf_n = 1'b1;
        acc_n = ACC_W'(dig);
      end else if (prod > 13'(dqv_pkg::ACCUM_SAT)) begin
        acc_n = dqv_pkg::ACCUM_SAT;
      end else begin
        acc_n = prod[ACC_W-1:0];
      end
    end else if (word_i.char_code != dqv_pkg::CHAR_DOT) begin
      bad_n = 1'b1;
    end

    sh = {~fc_n[1:0], 3'b000};
    if ((word_i.char_code == dqv_pkg::CHAR_DOT || word_i.last_char) && inf_n) begin
      if (fc_n < FC_W'(dqv_pkg::NUM_FIELDS)) begin
        if (acc_n > dqv_pkg::FIELD_MAX) begin
          rng_n = 1'b1;
        end
        pack_n = pack_n | (Q_W'(acc_n[7:0]) << sh);
        fc_n   = fc_n + FC_W'(1);
      end
      inf_n = 1'b0;
      acc_n = '0;
    end

    ok  = (cnt_n >= CNT_W'(dqv_pkg::MIN_CHARS)) && !bad_n && !rng_n &&
          (fc_n >= FC_W'(dqv_pkg::NUM_FIELDS));
    inv = ~pack_n;
    if (mask_mode_i && (!pack_n[Q_W-1] || ((inv & (inv + Q_W'(1))) != '0))) begin
      ok = 1'b0;
    end
    res_ok   = ok;
    res_quad = ok ? pack_n : '0;

    if (word_i.last_char) begin
      cnt_d  = '0;
      acc_d  = '0;
      inf_d  = 1'b0;
      fc_d   = '0;
      bad_d  = 1'b0;
      rng_d  = 1'b0;
      pack_d = '0;
    end else begin
      cnt_d  = cnt_n;
      acc_d  = acc_n;
      inf_d  = inf_n;
      fc_d   = fc_n;
      bad_d  = bad_n;
      rng_d  = rng_n;
      pack_d = pack_n;
    end
  end

  assign out_valid_d = (take_o && word_i.last_char) || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      acc_q       <= '0;
      inf_q       <= 1'b0;
      fc_q        <= '0;
      bad_q       <= 1'b0;
      rng_q       <= 1'b0;
      pack_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        cnt_q  <= cnt_d;
        acc_q  <= acc_d;
        inf_q  <= inf_d;
        fc_q   <= fc_d;
        bad_q  <= bad_d;
        rng_q  <= rng_d;
        pack_q <= pack_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && word_i.last_char) begin
      out_ok_q   <= res_ok;
      out_quad_q <= res_quad;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.is_valid   = out_ok_q;
  assign out_o.quad_value = out_quad_q;

  a_rise_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(take_o && word_i.last_char))
    else $error("result raised without a final character");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && word_i.last_char) |=> (cnt_q == '0 && fc_q == '0 && pack_q == '0))
    else $error("string state not cleared after final character");

  a_fc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FC_W'(dqv_pkg::NUM_FIELDS))
    else $error("field count beyond four");

  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inf_q |-> (acc_q == '0))
    else $error("accumulator not clear outside a token");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_quad_q == '0))
    else $error("rejected string carries a value");

endmodule : dqv_scan
`default_nettype wire

// ===== hdl/dotted_quad_validator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dotted-quad validator unit
// Checks a character stream as a dotted-decimal IPv4 address or netmask.
// ----------------------------------------------------------------------------
// The final character passes the input register and, once the result register
// is free, is taken by the scanner, which registers the result word.
// Throughput: one character per cycle, set by the single-pass scanner update.
// A result stalled at the output holds back only further final characters.
// Reset clears the string state, the result valid and mask_mode to address.
// ----------------------------------------------------------------------------
module dotted_quad_validator_unit #(
  parameter int unsigned MAX_CHARS = dqv_pkg::MAX_CHARS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dqv_char_if.sink  in_i,
  dqv_res_if.source out_o,
  dqv_cfg_if.sink   cfg_i
);

  logic               mask_mode_q;
  logic               take;
  logic               s_valid;
  dqv_pkg::dqv_char_t s_word;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mask_mode_q <= cfg_i.mask_mode;
    end
  end

  dqv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .word_o  (s_word),
    .valid_o (s_valid)
  );

  dqv_scan #(
    .MAX_CHARS (MAX_CHARS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (s_word),
    .valid_i     (s_valid),
    .mask_mode_i (mask_mode_q),
    .take_o      (take),
    .out_o       (out_o)
  );

endmodule : dotted_quad_validator_unit
`default_nettype wire

// ===== verif/dqv_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dotted-quad validator result checker
// Watches the character, configuration and result channels, keeps its own
// copy of the string scanner, predicts each result word from the accepted
// characters and compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
module dqv_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dqv_char_if         char_mon_i,
  dqv_res_if          res_mon_i,
  dqv_cfg_if          cfg_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned accepted_o
);

  typedef struct packed {
    logic                       is_valid;
    logic [dqv_pkg::QUAD_W-1:0] quad_value;
  } verdict_t;

  verdict_t expected_verdicts[$];

  logic                        mask_mode_q;
  logic [4:0]                  n_chars;
  logic [dqv_pkg::ACCUM_W-1:0] tok_accum;
  logic                        tok_open;
  logic [dqv_pkg::FCNT_W-1:0]  n_tokens;
  logic                        saw_bad;
  logic                        over_range;
  logic [dqv_pkg::QUAD_W-1:0]  quad_acc;

  int unsigned n_fail;
  int unsigned n_checked;
  int unsigned n_accepted;

  function automatic void close_token();
    if (tok_open) begin
      if (n_tokens < dqv_pkg::NUM_FIELDS) begin
        if (tok_accum > dqv_pkg::FIELD_MAX) over_range = 1'b1;
        quad_acc = quad_acc | ({24'd0, tok_accum[7:0]} << (24 - 8 * n_tokens));
        n_tokens = n_tokens + 1'b1;
      end
      tok_open  = 1'b0;
      tok_accum = '0;
    end
  endfunction

  function automatic void clear_string();
    n_chars    = '0;
    tok_accum  = '0;
    tok_open   = 1'b0;
    n_tokens   = '0;
    saw_bad    = 1'b0;
    over_range = 1'b0;
    quad_acc   = '0;
  endfunction

  function automatic void scan_char(input logic [dqv_pkg::CHAR_W-1:0] code,
                                    input logic is_last);
    logic [31:0]                next_val;
    logic                       ok;
    logic [dqv_pkg::QUAD_W-1:0] inv;
    if (n_chars >= dqv_pkg::MAX_CHARS_DEF) over_range = 1'b1;
    else n_chars = n_chars + 1'b1;
    if (code >= dqv_pkg::CHAR_ZERO && code <= dqv_pkg::CHAR_NINE) begin
      if (!tok_open) begin
        tok_open  = 1'b1;
        tok_accum = {1'b0, code - dqv_pkg::CHAR_ZERO};
      end else begin
        next_val  = tok_accum * 10 + (code - dqv_pkg::CHAR_ZERO);
        tok_accum = (next_val > dqv_pkg::ACCUM_SAT) ? dqv_pkg::ACCUM_SAT
                                                    : next_val[dqv_pkg::ACCUM_W-1:0];
      end
    end else if (code == dqv_pkg::CHAR_DOT) begin
      close_token();
    end else begin
      saw_bad = 1'b1;
    end
    if (is_last) begin
      close_token();
      ok = (n_chars >= dqv_pkg::MIN_CHARS) && !saw_bad && !over_range &&
           (n_tokens >= dqv_pkg::NUM_FIELDS);
      if (ok && mask_mode_q) begin
        inv = ~quad_acc;
        if (!quad_acc[dqv_pkg::QUAD_W-1] || ((inv & (inv + 1)) != 0)) ok = 1'b0;
      end
      expected_verdicts.push_back('{is_valid: ok, quad_value: ok ? quad_acc : '0});
      clear_string();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    verdict_t want;
    if (!rst_ni) begin
      mask_mode_q = 1'b0;
      clear_string();
      expected_verdicts.delete();
      n_fail       = 0;
      n_checked    = 0;
      n_accepted   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      accepted_o   <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) mask_mode_q = cfg_mon_i.mask_mode;
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (expected_verdicts.size() == 0) begin
          if (n_fail < 10)
            $display("[%0t] result word with nothing expected: is_valid %0b quad %h",
                     $time, res_mon_i.is_valid, res_mon_i.quad_value);
          n_fail++;
        end else begin
          want = expected_verdicts.pop_front();
          n_checked++;
          if (want.is_valid) n_accepted++;
          if (res_mon_i.is_valid !== want.is_valid ||
              res_mon_i.quad_value !== want.quad_value) begin
            if (n_fail < 10)
              $display("[%0t] mismatch: is_valid exp %0b got %0b, quad exp %h got %h",
                       $time, want.is_valid, res_mon_i.is_valid,
                       want.quad_value, res_mon_i.quad_value);
            n_fail++;
          end
        end
      end
      if (char_mon_i.valid && char_mon_i.ready)
        scan_char(char_mon_i.char_code, char_mon_i.last_char);
      fail_count_o <= n_fail;
      pending_o    <= expected_verdicts.size();
      checked_o    <= n_checked;
      accepted_o   <= n_accepted;
    end
  end

endmodule : dqv_result_checker

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dotted-quad validator testbench
// Sends short directed strings, then phases of random strings (addresses,
// netmasks, over-long strings, corrupted strings and noise) in both modes,
// with bursty input, a stalling result sink and one long output hold-off.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_CHARS = 1750;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef logic [dqv_pkg::CHAR_W-1:0] char_q_t[$];

  logic clk;
  logic rst_n;
  logic hold_off;
  logic hold_start;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned accepted;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned strings_sent;
  int unsigned chars_sent;

  dqv_char_if char_ch ();
  dqv_res_if  res_ch ();
  dqv_cfg_if  cfg_ch ();

  dotted_quad_validator_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (char_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  dqv_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .char_mon_i   (char_ch),
    .res_mon_i    (res_ch),
    .cfg_mon_i    (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .accepted_o   (accepted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    int unsigned run_left;
    logic        run_on;
    run_left     = 0;
    run_on       = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        run_on = !run_on;
        if (run_on)
          run_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
        else
          run_left = $urandom_range(1, 6);
      end
      run_left--;
      res_ch.ready <= run_on && !hold_off;
    end
  end

  initial begin : hold_process
    int unsigned held;
    hold_off = 1'b0;
    wait (hold_start);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_char(input logic [dqv_pkg::CHAR_W-1:0] code, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        char_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= code;
    char_ch.last_char <= is_last;
    do @(posedge clk); while (!char_ch.ready);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_string(input char_q_t s);
    int unsigned k;
    for (k = 0; k < s.size(); k++) send_char(s[k], k == s.size() - 1);
    strings_sent++;
  endtask

  // drop valid, drain the expected words, then let the pipeline settle
  task automatic wait_idle();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.mask_mode <= mode;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void push_text(inout char_q_t q, input string s);
    int k;
    for (k = 0; k < s.len(); k++) q.push_back(s.getc(k));
  endfunction

  function automatic char_q_t text_chars(input string s);
    char_q_t q;
    push_text(q, s);
    return q;
  endfunction

  function automatic void push_dec(inout char_q_t q, input int unsigned v,
                                   input int unsigned zeros);
    repeat (zeros) q.push_back(dqv_pkg::CHAR_ZERO);
    push_text(q, $sformatf("%0d", v));
  endfunction

  function automatic char_q_t random_string();
    char_q_t       q;
    int unsigned   pick;
    int unsigned   k;
    int unsigned   tok;
    int unsigned   n_tok;
    int unsigned   len;
    logic [31:0]   m;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if (pick < 25) begin
        len = $urandom_range(0, 32);
        m   = (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
        if ($urandom_range(0, 3) == 0) m[$urandom_range(0, 31)] = ~m[$urandom_range(0, 31)];
      end else begin
        m = $urandom();
      end
      n_tok = 4;
      if ($urandom_range(0, 9) == 0) n_tok = $urandom_range(5, 6);
      else if ($urandom_range(0, 19) == 0) n_tok = 3;
      if ($urandom_range(0, 9) == 0) q.push_back(dqv_pkg::CHAR_DOT);
      for (k = 0; k < n_tok; k++) begin
        if (k > 0) begin
          q.push_back(dqv_pkg::CHAR_DOT);
          if ($urandom_range(0, 14) == 0) q.push_back(dqv_pkg::CHAR_DOT);
        end
        tok = (k < 4) ? m[31 - 8 * k -: 8] : $urandom_range(0, 255);
        if ($urandom_range(0, 11) == 0) tok = $urandom_range(256, 999);
        push_dec(q, tok, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
      end
      if ($urandom_range(0, 9) == 0) q.push_back(dqv_pkg::CHAR_DOT);
      if (pick >= 60) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 80) begin
      // padded fields straddle the length limit
      for (k = 0; k < 4; k++) begin
        if (k > 0) q.push_back(dqv_pkg::CHAR_DOT);
        push_dec(q, $urandom_range(0, 255), $urandom_range(1, 3));
      end
    end else begin
      len = $urandom_range(1, 20);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 2) == 0) q.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 3) == 0) q.push_back(dqv_pkg::CHAR_DOT);
        else q.push_back(8'(dqv_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end
    end
    return q;
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned base;
    rst_n             = 1'b0;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    char_ch.last_char = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.mask_mode  = 1'b0;
    burst_left        = 0;
    strings_sent      = 0;
    chars_sent        = 0;
    hold_start        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(1'b0);
    send_string(text_chars("5"));
    send_string(text_chars("0.0.0.0"));
    send_string(text_chars("999.1.2.3"));
    wait_idle();
    write_mode(1'b1);
    send_string(text_chars("255.0.0.0"));
    send_string(text_chars("1.2.3.4"));

    base = chars_sent;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_mode(phase[0]);
      hold_start = 1'b1;
      while (chars_sent < base + (phase + 1) * RANDOM_CHARS / PHASES)
        send_string(random_string());
    end
    wait_idle();

    $display("run covered %0d strings of %0d characters over %0d mode phases",
             strings_sent, chars_sent, PHASES + 2);
    $display("%0d result words checked, %0d of them predicted well formed",
             checked, accepted);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : tb_top

// ===== filelist.f =====
hdl/dqv_pkg.sv
hdl/dqv_if.sv
hdl/dqv_in_reg.sv
hdl/dqv_scan.sv
hdl/dotted_quad_validator_unit.sv
verif/dqv_result_checker.sv
verif/tb_top.sv
